FILE: src/sttl_pkg.sv
// Shared types and codes for the sorted tag lookup table.
// Holds request/result item structs, status and request codes, controller
// state enum and the command/status bundles between controller and datapath.
package sttl_pkg;

    // Request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_ABSENT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ORDER    = 3'd4;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] tag_id;
        logic [9:0]  entry_slot;
    } t_req;

    // Result item
    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  found_slot;
        logic [10:0] entry_count;
    } t_rsp;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_SCAN_CMP
    } t_state;

    // Read address source for the store read port
    typedef enum logic [1:0] {
        A_MID,
        A_LO,
        A_NEXT
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;       // capture the accepted item
        logic       clear;       // empty the table
        logic       append;      // write the item's tag and slot
        logic       init_range;  // lo = 0, hi = count - 1
        logic       probe;       // remember the midpoint being read
        logic       step;        // narrow lo/hi by the probed tag
        logic       scan_start;  // pos = lo
        logic       scan_next;   // pos = pos + 1
        t_addr_sel  addr_sel;
        logic       respond;     // load the result register
        logic [2:0] rsp_status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] req_type;
        logic       empty;
        logic       full;
        logic       order_ok;
        logic       in_range;
        logic       span_gt2;
        logic       hit;
        logic       at_hi;
    } t_stat;

endpackage

FILE: src/sorted_tag_lookup_table.sv
// Top level of the sorted tag lookup table: controller plus datapath.
// Depends on sttl_pkg, sttl_ctrl and sttl_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  request  | start in, busy out     | i_req  (sttl_pkg::t_req)
//  result   | o_done strobe out      | o_rsp  (sttl_pkg::t_rsp)
//
// An item is taken when start is high and busy is low; its single result is
// shown for one cycle with o_done. Clear, append and rejected or out-of-range
// lookups are answered from the decode state. A lookup that searches makes
// halving probes (about log2 of the entry count, minus one), each a read and
// then a compare on the single registered read port of the tag store, and
// then 1 to 3 final scan compares. Reset is synchronous, active low,
// and empties the table; o_done cannot be held off by the receiver.
module sorted_tag_lookup_table #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sttl_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output sttl_pkg::t_rsp o_rsp
);

    sttl_pkg::t_cmd  cmd;
    sttl_pkg::t_stat stat;

    sttl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    sttl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: src/sttl_ctrl.sv
// Controller state machine for the sorted tag lookup table.
// Depends on sttl_pkg for states, codes and the command/status bundles.
module sttl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sttl_pkg::t_stat i_stat,
    output logic           busy,
    output logic           o_done,
    output sttl_pkg::t_cmd  o_cmd
);

    sttl_pkg::t_state r_state, n_state;
    logic             r_done;

    // State and done strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sttl_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.respond;
        end
    end

    assign busy   = (r_state != sttl_pkg::S_IDLE);
    assign o_done = r_done;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sttl_pkg::S_IDLE: begin
                if (start) n_state = sttl_pkg::S_DECODE;
            end
            sttl_pkg::S_DECODE: begin
                if (i_stat.req_type == sttl_pkg::REQ_LOOKUP && !i_stat.empty
                    && i_stat.in_range) begin
                    n_state = sttl_pkg::S_PROBE_RD;
                end else begin
                    n_state = sttl_pkg::S_IDLE;
                end
            end
            sttl_pkg::S_PROBE_RD: begin
                if (i_stat.span_gt2) n_state = sttl_pkg::S_PROBE_CMP;
                else                 n_state = sttl_pkg::S_SCAN_CMP;
            end
            sttl_pkg::S_PROBE_CMP: begin
                n_state = sttl_pkg::S_PROBE_RD;
            end
            sttl_pkg::S_SCAN_CMP: begin
                if (i_stat.hit || i_stat.at_hi) n_state = sttl_pkg::S_IDLE;
            end
            default: n_state = sttl_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.addr_sel   = sttl_pkg::A_MID;
        o_cmd.rsp_status = sttl_pkg::ST_ABSENT;
        unique case (r_state)
            sttl_pkg::S_IDLE: begin
                o_cmd.latch = start;
            end
            sttl_pkg::S_DECODE: begin
                unique case (i_stat.req_type)
                    sttl_pkg::REQ_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.respond    = 1'b1;
                        o_cmd.rsp_status = sttl_pkg::ST_ACCEPTED;
                    end
                    sttl_pkg::REQ_APPEND: begin
                        o_cmd.respond = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.rsp_status = sttl_pkg::ST_FULL;
                        end else if (!i_stat.order_ok) begin
                            o_cmd.rsp_status = sttl_pkg::ST_ORDER;
                        end else begin
                            o_cmd.append     = 1'b1;
                            o_cmd.rsp_status = sttl_pkg::ST_ACCEPTED;
                        end
                    end
                    sttl_pkg::REQ_LOOKUP: begin
                        // Empty table or tag outside first..last answers at once
                        if (i_stat.empty || !i_stat.in_range) begin
                            o_cmd.respond = 1'b1;
                        end else begin
                            o_cmd.init_range = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.respond = 1'b1;
                    end
                endcase
            end
            sttl_pkg::S_PROBE_RD: begin
                if (i_stat.span_gt2) begin
                    o_cmd.probe    = 1'b1;
                    o_cmd.addr_sel = sttl_pkg::A_MID;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.addr_sel   = sttl_pkg::A_LO;
                end
            end
            sttl_pkg::S_PROBE_CMP: begin
                o_cmd.step = 1'b1;
            end
            sttl_pkg::S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.respond    = 1'b1;
                    o_cmd.rsp_status = sttl_pkg::ST_FOUND;
                end else if (i_stat.at_hi) begin
                    o_cmd.respond = 1'b1;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    o_cmd.addr_sel  = sttl_pkg::A_NEXT;
                end
            end
            default: begin
                o_cmd.respond = 1'b0;
            end
        endcase
    end

    // A result only follows decode or a scan compare
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == sttl_pkg::S_DECODE
                    || $past(r_state) == sttl_pkg::S_SCAN_CMP))
        else $error("done strobe from unexpected state");

    // An accepted item is decoded in the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == sttl_pkg::S_DECODE))
        else $error("accepted item not decoded");

    // A scan hit is reported in the following cycle
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sttl_pkg::S_SCAN_CMP && i_stat.hit) |=> r_done)
        else $error("scan hit not reported");

endmodule

FILE: src/sttl_datapath.sv
// Datapath for the sorted tag lookup table: tag and slot stores, fill count,
// search bounds and the result register. Depends on sttl_pkg.
module sttl_datapath #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sttl_pkg::t_req  i_req,
    input  sttl_pkg::t_cmd  i_cmd,
    output sttl_pkg::t_stat o_stat,
    output sttl_pkg::t_rsp  o_rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FW = $clog2(MAX_ENTRIES + 1);

    // Stores: one write port at the fill index, one registered read port
    logic [31:0] r_tag_mem  [MAX_ENTRIES];
    logic [9:0]  r_slot_mem [MAX_ENTRIES];

    sttl_pkg::t_req r_req;
    sttl_pkg::t_rsp r_rsp;
    logic [FW-1:0]  r_fill, n_fill;
    logic [31:0]    r_last;
    logic [31:0]    r_first;
    logic [AW-1:0]  r_lo, r_hi, r_mid, r_pos;
    logic [31:0]    r_rd_tag;
    logic [9:0]     r_rd_slot;

    logic [AW:0]    mid_sum;
    logic [AW-1:0]  mid;
    logic [AW-1:0]  span;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[AW:1];
    assign span    = r_hi - r_lo;
    assign wr_addr = AW'(r_fill);

    // Read address select
    always_comb begin
        unique case (i_cmd.addr_sel)
            sttl_pkg::A_MID:  rd_addr = mid;
            sttl_pkg::A_LO:   rd_addr = r_lo;
            sttl_pkg::A_NEXT: rd_addr = r_pos + AW'(1);
            default:          rd_addr = mid;
        endcase
    end

    // Store access
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_tag_mem[wr_addr]  <= r_req.tag_id;
            r_slot_mem[wr_addr] <= r_req.entry_slot;
        end
        r_rd_tag  <= r_tag_mem[rd_addr];
        r_rd_slot <= r_slot_mem[rd_addr];
    end

    // Fill count after this item
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.clear)       n_fill = '0;
        else if (i_cmd.append) n_fill = r_fill + FW'(1);
    end

    // Table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_last <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.clear)       r_last <= '0;
            else if (i_cmd.append) r_last <= r_req.tag_id;
        end
    end

    // Item capture, first tag and search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_req <= i_req;
        if (i_cmd.append && r_fill == '0) r_first <= r_req.tag_id;
        if (i_cmd.init_range) begin
            r_lo <= '0;
            r_hi <= AW'(r_fill - FW'(1));
        end
        if (i_cmd.probe) r_mid <= mid;
        if (i_cmd.step) begin
            if (r_req.tag_id > r_rd_tag) r_lo <= r_mid;
            else                         r_hi <= r_mid;
        end
        if (i_cmd.scan_start)     r_pos <= r_lo;
        else if (i_cmd.scan_next) r_pos <= r_pos + AW'(1);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_rsp.status      <= i_cmd.rsp_status;
            r_rsp.found_slot  <= (i_cmd.rsp_status == sttl_pkg::ST_FOUND) ? r_rd_slot : '0;
            r_rsp.entry_count <= 11'(n_fill);
        end
    end

    assign o_rsp = r_rsp;

    // Status to controller
    assign o_stat.req_type = r_req.req_type;
    assign o_stat.empty    = (r_fill == '0);
    assign o_stat.full     = (r_fill == FW'(MAX_ENTRIES));
    assign o_stat.order_ok = (r_fill == '0) || (r_req.tag_id > r_last);
    assign o_stat.in_range = (r_req.tag_id >= r_first) && (r_req.tag_id <= r_last);
    assign o_stat.span_gt2 = ((AW + 2)'(span) > (AW + 2)'(2));
    assign o_stat.hit      = (r_rd_tag == r_req.tag_id);
    assign o_stat.at_hi    = (r_pos == r_hi);

    // Fill count never passes capacity
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_ENTRIES))
        else $error("fill count above capacity");

    // A narrowing step always has its midpoint strictly inside the bounds
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_lo < r_mid) && (r_mid < r_hi))
        else $error("probe midpoint outside bounds");

    // Appends are written only when room and order allow
    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (!o_stat.full && o_stat.order_ok))
        else $error("append written against full or order check");

endmodule
